@@ rtl/core/accel_orientation_classifier_macros.svh @@
// Assertion macros for the accel orientation classifier
`ifndef ACCEL_ORIENTATION_CLASSIFIER_MACROS_SVH
`define ACCEL_ORIENTATION_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define AOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AOC_ASSERT_IMP(lbl, ante, cons, msg)
`define AOC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/aoc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the rotation proposal function
package aoc_pkg;

  localparam int unsigned AccelW  = 14;
  localparam int unsigned ThrW    = 13;
  localparam int unsigned StabW   = 18;
  localparam int unsigned SqW     = 28;
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    ROT_LAND     = 3'd0,
    ROT_LAND_INV = 3'd1,
    ROT_PORT     = 3'd2,
    ROT_PORT_INV = 3'd3,
    ROT_UNKNOWN  = 3'd4
  } rot_code_t;

  typedef enum logic [2:0] {
    CFG_STABLE_MIN  = 3'd0,
    CFG_STABLE_MAX  = 3'd1,
    CFG_FACE_Z_MIN  = 3'd2,
    CFG_FACE_XY_MAX = 3'd3,
    CFG_NEAR_ZERO   = 3'd4
  } cfg_idx_t;

  localparam logic [StabW-1:0] StableMinRst = 18'd640;
  localparam logic [StabW-1:0] StableMaxRst = 18'd1440;
  localparam logic [ThrW-1:0]  FaceZMinRst  = 13'd900;
  localparam logic [ThrW-1:0]  FaceXyMaxRst = 13'd300;
  localparam logic [ThrW-1:0]  NearZeroRst  = 13'd100;

  // floor(sum/1000) is compared through scaled bounds
  localparam logic [SqW-1:0] MilliScale = 28'd1000;

  localparam logic [AccelW-1:0] RotDeadBand  = 14'd200;
  localparam logic [AccelW-1:0] RotDominant  = 14'd400;
  localparam logic [AccelW:0]   RotHyst      = 15'd300;
  localparam logic [AccelW-1:0] StandAxExit  = 14'd240;
  localparam logic signed [AccelW:0] StandYEnter = -15'sd400;
  localparam logic signed [AccelW:0] StandYExit  = -15'sd200;

  localparam logic [3:0] FsNormal = 4'd2;
  localparam logic [3:0] FsWide   = 4'd8;

  typedef struct packed {
    logic                     action;
    logic                     sample_valid;
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
    logic                     range_normal;
    logic                     display_active;
  } in_item_t;

  typedef struct packed {
    logic       result_valid;
    logic [2:0] rotation;
    logic       on_stand;
    logic       face_down;
    logic [3:0] full_scale_g;
    logic       changed;
    logic       wake_request;
  } out_item_t;

  function automatic logic [2:0] propose_rot(input logic [2:0] old_rot,
                                             input logic [AccelW-1:0] ax,
                                             input logic [AccelW-1:0] ay,
                                             input logic x_neg,
                                             input logic y_neg);
    logic [2:0] land;
    logic [2:0] port;
    logic [2:0] res;
    land = y_neg ? ROT_LAND : ROT_LAND_INV;
    port = x_neg ? ROT_PORT : ROT_PORT_INV;
    res  = old_rot;
    if (ax < RotDeadBand && ay < RotDeadBand) begin
      res = ROT_UNKNOWN;
    end else if (old_rot == ROT_UNKNOWN) begin
      if (ay > RotDominant && ay > ax) begin
        res = land;
      end else if (ax > RotDominant && ax > ay) begin
        res = port;
      end
    end else if (old_rot == ROT_LAND || old_rot == ROT_LAND_INV) begin
      res = ({1'b0, ax} > {1'b0, ay} + RotHyst) ? port : land;
    end else if (old_rot == ROT_PORT || old_rot == ROT_PORT_INV) begin
      res = ({1'b0, ay} > {1'b0, ax} + RotHyst) ? land : port;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/aoc_in_if.sv @@
`timescale 1ns / 1ps
// Sample request channel
interface aoc_in_if import aoc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic                     sample_valid;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic                     range_normal;
  logic                     display_active;

  modport source (output valid, action, sample_valid, accel_x, accel_y, accel_z,
                  range_normal, display_active, input ready);
  modport sink (input valid, action, sample_valid, accel_x, accel_y, accel_z,
                range_normal, display_active, output ready);
endinterface

@@ rtl/core/aoc_out_if.sv @@
`timescale 1ns / 1ps
// Classification result channel
interface aoc_out_if;
  logic       valid;
  logic       ready;
  logic       result_valid;
  logic [2:0] rotation;
  logic       on_stand;
  logic       face_down;
  logic [3:0] full_scale_g;
  logic       changed;
  logic       wake_request;

  modport source (output valid, result_valid, rotation, on_stand, face_down,
                  full_scale_g, changed, wake_request, input ready);
  modport sink (input valid, result_valid, rotation, on_stand, face_down,
                full_scale_g, changed, wake_request, output ready);
endinterface

@@ rtl/core/accel_orientation_classifier.sv @@
`timescale 1ns / 1ps
// Accelerometer orientation classifier top level
//
//   channel   | dir | handshake           | carries
//   in_chan   | in  | valid/ready         | one sample request
//   out_chan  | out | valid/ready         | one result per request
//   apb port  | in  | psel/penable/pready | five threshold registers
//
// The input register feeds magnitude, hysteresis and rotation logic into the
// result register. One request per cycle sustained while out_chan.ready holds;
// the three 14x14 squares and the scaled bound compares set the path.
// rst_n is synchronous; it restores the register defaults and clears state.
// A stalled result holds the input register, which then holds in_chan.ready low.

`include "accel_orientation_classifier_macros.svh"

module accel_orientation_classifier import aoc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  aoc_in_if.sink              in_chan,
  aoc_out_if.source           out_chan,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [StabW-1:0] stable_min_r;
  logic [StabW-1:0] stable_max_r;
  logic [ThrW-1:0]  face_z_min_r;
  logic [ThrW-1:0]  face_xy_max_r;
  logic [ThrW-1:0]  near_zero_r;
  logic [SqW-1:0]   lo_sq;
  logic [SqW-1:0]   hi_sq;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  res_r;
  out_item_t  res_nxt;

  logic [2:0] rot_r, rot_nxt;
  logic       stand_r, stand_nxt;
  logic       face_r, face_nxt;
  logic [2:0] pend_rot_r, pend_rot_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic       wake_nxt;

  logic       adv;
  logic       fire;
  logic       in_ready;
  logic       cfg_wr;
  cfg_idx_t   cfg_idx;

  logic [AccelW-1:0]        ax, ay, az;
  logic [SqW-1:0]           sq_x, sq_y, sq_z, sq_sum;
  logic                     stable;
  logic [2:0]               prop_rot;
  logic signed [AccelW:0]   y_s, z_s, nz_neg;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_min_r  <= StableMinRst;
      stable_max_r  <= StableMaxRst;
      face_z_min_r  <= FaceZMinRst;
      face_xy_max_r <= FaceXyMaxRst;
      near_zero_r   <= NearZeroRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_STABLE_MIN:  stable_min_r  <= pwdata[StabW-1:0];
        CFG_STABLE_MAX:  stable_max_r  <= pwdata[StabW-1:0];
        CFG_FACE_Z_MIN:  face_z_min_r  <= pwdata[ThrW-1:0];
        CFG_FACE_XY_MAX: face_xy_max_r <= pwdata[ThrW-1:0];
        CFG_NEAR_ZERO:   near_zero_r   <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_STABLE_MIN:  prdata = {{(32-StabW){1'b0}}, stable_min_r};
      CFG_STABLE_MAX:  prdata = {{(32-StabW){1'b0}}, stable_max_r};
      CFG_FACE_Z_MIN:  prdata = {{(32-ThrW){1'b0}}, face_z_min_r};
      CFG_FACE_XY_MAX: prdata = {{(32-ThrW){1'b0}}, face_xy_max_r};
      CFG_NEAR_ZERO:   prdata = {{(32-ThrW){1'b0}}, near_zero_r};
      default:         prdata = '0;
    endcase
  end

  // g < min  <=>  sum < min*1000 ; g > max  <=>  sum >= (max+1)*1000
  assign lo_sq = SqW'(stable_min_r) * MilliScale;
  assign hi_sq = (SqW'(stable_max_r) + 28'd1) * MilliScale;

  // ---------------- handshake ----------------
  assign adv            = !out_valid_r || out_chan.ready;
  assign fire           = s1_valid_r && adv;
  assign in_ready       = !s1_valid_r || adv;
  assign in_chan.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_item_r.action         <= in_chan.action;
      s1_item_r.sample_valid   <= in_chan.sample_valid;
      s1_item_r.accel_x        <= in_chan.accel_x;
      s1_item_r.accel_y        <= in_chan.accel_y;
      s1_item_r.accel_z        <= in_chan.accel_z;
      s1_item_r.range_normal   <= in_chan.range_normal;
      s1_item_r.display_active <= in_chan.display_active;
    end
  end

  // ---------------- datapath ----------------
  assign ax = s1_item_r.accel_x[AccelW-1] ? AccelW'(-s1_item_r.accel_x)
                                          : s1_item_r.accel_x;
  assign ay = s1_item_r.accel_y[AccelW-1] ? AccelW'(-s1_item_r.accel_y)
                                          : s1_item_r.accel_y;
  assign az = s1_item_r.accel_z[AccelW-1] ? AccelW'(-s1_item_r.accel_z)
                                          : s1_item_r.accel_z;

  assign sq_x   = SqW'(ax) * SqW'(ax);
  assign sq_y   = SqW'(ay) * SqW'(ay);
  assign sq_z   = SqW'(az) * SqW'(az);
  assign sq_sum = sq_x + sq_y + sq_z;
  assign stable = (sq_sum >= lo_sq) && (sq_sum < hi_sq);

  assign y_s    = {s1_item_r.accel_y[AccelW-1], s1_item_r.accel_y};
  assign z_s    = {s1_item_r.accel_z[AccelW-1], s1_item_r.accel_z};
  assign nz_neg = -$signed({2'b00, near_zero_r});

  assign prop_rot = propose_rot(rot_r, ax, ay, s1_item_r.accel_x[AccelW-1],
                                s1_item_r.accel_y[AccelW-1]);

  always_comb begin
    face_nxt     = face_r;
    stand_nxt    = stand_r;
    rot_nxt      = rot_r;
    pend_rot_nxt = pend_rot_r;
    pend_v_nxt   = pend_v_r;
    wake_nxt     = 1'b0;
    if (s1_item_r.sample_valid) begin
      if (!face_r) begin
        if (z_s > $signed({2'b00, face_z_min_r}) && ax < {1'b0, face_xy_max_r} &&
            ay < {1'b0, face_xy_max_r}) begin
          face_nxt = 1'b1;
        end
      end else if (z_s < nz_neg) begin
        face_nxt = 1'b0;
      end

      if (!stand_r) begin
        if (ax < {1'b0, near_zero_r} && y_s < StandYEnter && z_s < nz_neg) begin
          stand_nxt = 1'b1;
        end
      end else if (ax > StandAxExit || y_s > StandYExit || z_s > 15'sd0) begin
        stand_nxt = 1'b0;
      end

      if (!stable) begin
        pend_v_nxt = 1'b0;
      end else if (!s1_item_r.action) begin
        rot_nxt = prop_rot;
      end else if (prop_rot != rot_r) begin
        if (pend_v_r && pend_rot_r == prop_rot) begin
          rot_nxt    = prop_rot;
          pend_v_nxt = 1'b0;
          wake_nxt   = s1_item_r.display_active &&
                       (rot_r == ROT_LAND || prop_rot == ROT_LAND) &&
                       (rot_r == ROT_PORT || prop_rot == ROT_PORT);
        end else begin
          pend_rot_nxt = prop_rot;
          pend_v_nxt   = 1'b1;
        end
      end else begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res_nxt.result_valid = s1_item_r.sample_valid;
    res_nxt.rotation     = rot_nxt;
    res_nxt.on_stand     = stand_nxt;
    res_nxt.face_down    = face_nxt;
    res_nxt.wake_request = wake_nxt;
    res_nxt.changed      = (rot_nxt != rot_r) || (face_nxt != face_r);
    if (!s1_item_r.sample_valid) begin
      res_nxt.full_scale_g = '0;
    end else begin
      res_nxt.full_scale_g = s1_item_r.range_normal ? FsNormal : FsWide;
    end
  end

  // ---------------- state and result registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r      <= ROT_LAND;
      stand_r    <= 1'b0;
      face_r     <= 1'b0;
      pend_rot_r <= ROT_LAND;
      pend_v_r   <= 1'b0;
    end else if (fire) begin
      rot_r      <= rot_nxt;
      stand_r    <= stand_nxt;
      face_r     <= face_nxt;
      pend_rot_r <= pend_rot_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_valid = res_r.result_valid;
  assign out_chan.rotation     = res_r.rotation;
  assign out_chan.on_stand     = res_r.on_stand;
  assign out_chan.face_down    = res_r.face_down;
  assign out_chan.full_scale_g = res_r.full_scale_g;
  assign out_chan.changed      = res_r.changed;
  assign out_chan.wake_request = res_r.wake_request;

  // ---------------- checks ----------------
  `AOC_ASSERT_IMP(a_wake_changes, out_valid_r && res_r.wake_request,
                  res_r.changed && res_r.result_valid, "wake without a rotation change")
  `AOC_ASSERT_IMP(a_invalid_quiet, out_valid_r && !res_r.result_valid,
                  !res_r.changed && !res_r.wake_request, "invalid sample changed state")
  `AOC_ASSERT_NEXT(a_wake_clears_pend, fire && wake_nxt, !pend_v_r,
                   "pending rotation kept after confirmation")
  `AOC_ASSERT_IMP(a_rot_range, 1'b1, rot_r <= ROT_UNKNOWN, "rotation state out of range")
  `AOC_ASSERT_NEXT(a_stall_holds_state, s1_valid_r && !adv, $stable(rot_r) && $stable(pend_v_r),
                   "state moved while result stalled")

endmodule
